// ===== rtl/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Gaussian beam intensity package
// Field widths, fixed-point constants, register codes and the functions that
// build the exponential tables at elaboration.
// ----------------------------------------------------------------------------
package gbi_pkg;

	// Field widths of the input, result and configuration words.
	localparam int AXIAL_W     = 48;
	localparam int RADIAL_W    = 40;
	localparam int INTENSITY_W = 64;
	localparam int RADIUS_W    = 48;
	localparam int WL_W        = 24;
	localparam int WAIST_W     = 20;
	localparam int POWER_W     = 32;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	// Fixed-point constants: pi in Q32, pi in Q32 times one million, and 2e12.
	localparam logic [33:0] PI_Q32     = 34'd13493037705;
	localparam logic [53:0] PI_Q32_1E6 = 54'd13493037705000000;
	localparam logic [40:0] TWO_E12    = 41'd2000000000000;

	// Register codes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_WAVELENGTH = 2'd0,
		REG_WAIST      = 2'd1,
		REG_POWER      = 2'd2
	} cfg_reg_t;

	// Shift-and-subtract division, used only to build constant tables.
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-j/segs) in Q52 by a 24-term series.
	function automatic logic [63:0] exp_node(input logic [63:0] j, input logic [63:0] segs);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = '0;
		term = 64'd1 << 52;
		for (int k = 0; k < 24; k++) begin
			if ((k & 1) == 0) begin
				sum = sum + term;
			end else begin
				sum = (sum > term) ? (sum - term) : '0;
			end
			term = div_u64(term * j, segs * 64'(k + 1));
		end
		return sum;
	endfunction

	// Table node rounded to Q32.
	function automatic logic [32:0] node_q32(input logic [63:0] j, input logic [63:0] segs);
		logic [63:0] e;
		e = exp_node(j, segs) + (64'd1 << 19);
		return 33'(e >> 20);
	endfunction

	// exp(-1) raised to the power n in Q52, truncated after every product.
	function automatic logic [52:0] exp_pow(input int n, input logic [63:0] segs);
		logic [63:0]  e;
		logic [63:0]  e1;
		logic [127:0] pr;
		e  = 64'd1 << 52;
		e1 = exp_node(segs, segs);
		for (int i = 0; i < 32; i++) begin
			if (i < n) begin
				pr = 128'(e) * 128'(e1);
				e  = pr[115:52];
			end
		end
		return 53'(e);
	endfunction

endpackage

// ===== rtl/gbi_point_if.sv =====
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel that carries one evaluation point per word.
// ----------------------------------------------------------------------------
interface gbi_point_if import gbi_pkg::*; ();

	logic                       valid;
	logic                       ready;
	logic signed [AXIAL_W-1:0]  axial_distance_um;
	logic signed [RADIAL_W-1:0] radial_offset_um;

	modport source (output valid, output axial_distance_um, output radial_offset_um,
		input ready);
	modport sink (input valid, input axial_distance_um, input radial_offset_um,
		output ready);

endinterface

// ===== rtl/gbi_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries intensity, beam radius and clip flag.
// ----------------------------------------------------------------------------
interface gbi_result_if import gbi_pkg::*; ();

	logic                   valid;
	logic                   ready;
	logic [INTENSITY_W-1:0] intensity_uw_per_m2;
	logic [RADIUS_W-1:0]    beam_radius_um;
	logic                   saturated;

	modport source (output valid, output intensity_uw_per_m2, output beam_radius_um,
		output saturated, input ready);
	modport sink (input valid, input intensity_uw_per_m2, input beam_radius_um,
		input saturated, output ready);

endinterface

// ===== rtl/gaussian_beam_intensity.sv =====
// Throughput: one word per cycle while the result word is taken or empty;
// the 56-step long-division chain for d and the 72-step shared chain, which
// also runs the 57-step square-root chain, set the pipeline depth.
// A stalled result holds the whole pipeline, which loses and repeats nothing.
// Reset clears all valid bits and loads the default wavelength, waist and power.
// ----------------------------------------------------------------------------
// Gaussian beam intensity
// Fully pipelined beam radius and intensity, one point per cycle when not stalled.
// ----------------------------------------------------------------------------
module gaussian_beam_intensity import gbi_pkg::*; #(
	parameter int EXP_SEGMENTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	gbi_point_if.sink             point,
	gbi_result_if.source          result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int SEG_W   = $clog2(EXP_SEGMENTS + 1);
	localparam int T_W     = 16 + SEG_W;
	localparam int D_STEPS = 56;
	localparam int U_STEPS = 72;
	localparam int S_STEPS = 57;
	localparam int X_STEPS = 21;
	localparam int N_STG   = 2 + (D_STEPS + 1) + 3 + (U_STEPS + 1) + 7 + 1;

	typedef struct packed {
		logic [71:0] numd;
		logic [79:0] r2;
		logic [73:0] rem;
		logic [55:0] q;
		logic        far;
	} dv_t;

	typedef struct packed {
		logic [79:0] r2;
		logic        far;
		logic [55:0] dll;
		logic [55:0] dlh;
		logic [55:0] dhh;
	} m1_t;

	typedef struct packed {
		logic [112:0] s;
		logic [79:0]  r2;
		logic         far;
	} m2_t;

	typedef struct packed {
		logic [112:0] s;
		logic [79:0]  r2;
		logic         far;
		logic         big;
		logic [63:0]  ps0;
		logic [63:0]  ps1;
		logic [63:0]  ps2;
	} m3_t;

	typedef struct packed {
		logic [112:0] s;
		logic [123:0] ps;
		logic         far;
		logic         big;
		logic         xover;
		logic [123:0] prem;
		logic [71:0]  pq;
		logic [57:0]  srem;
		logic [56:0]  root;
		logic [112:0] xrem;
		logic [20:0]  xq;
	} uv_t;

	typedef struct packed {
		logic          far;
		logic          satr;
		logic [47:0]   radius;
		logic [71:0]   peak;
		logic          gzero;
		logic [T_W-1:0] t;
		logic [4:0]    xi;
	} p1_t;

	typedef struct packed {
		logic        far;
		logic        satr;
		logic [47:0] radius;
		logic [71:0] peak;
		logic        gzero;
		logic [32:0] a;
		logic [32:0] b;
		logic [15:0] pos;
		logic [52:0] epow;
	} p2_t;

	typedef struct packed {
		logic        far;
		logic        satr;
		logic [47:0] radius;
		logic [71:0] peak;
		logic        gzero;
		logic [32:0] a;
		logic [48:0] prod;
		logic [52:0] epow;
	} p3_t;

	typedef struct packed {
		logic        far;
		logic        satr;
		logic [47:0] radius;
		logic [71:0] peak;
		logic        gzero;
		logic [32:0] f;
		logic [52:0] epow;
	} p4_t;

	typedef struct packed {
		logic        far;
		logic        satr;
		logic [47:0] radius;
		logic [71:0] peak;
		logic        gzero;
		logic [58:0] fel;
		logic [59:0] feh;
	} p5_t;

	typedef struct packed {
		logic        far;
		logic        satr;
		logic [47:0] radius;
		logic [71:0] peak;
		logic [32:0] g;
	} p6_t;

	typedef struct packed {
		logic        far;
		logic        satr;
		logic [47:0] radius;
		logic [56:0] pp0;
		logic [56:0] pp1;
		logic [56:0] pp2;
	} p7_t;

	// Configuration registers and their derived constants.
	logic [WL_W-1:0]    wavelength_q;
	logic [WAIST_W-1:0] waist_q;
	logic [POWER_W-1:0] power_q;
	logic [19:0]        w0_q;
	logic [46:0]        dden_lo_q;
	logic [46:0]        dden_hi_q;
	logic [73:0]        dden_q;
	logic [39:0]        w0sq_q;
	logic [52:0]        npk_lo_q;
	logic [51:0]        npk_hi_q;
	logic [72:0]        npk_q;

	// Pipeline control.
	logic             adv;
	logic [N_STG-1:0] stage_vld_q;

	// Pipeline registers.
	logic [47:0] za_s1;
	logic [39:0] ra_s1;
	logic [47:0] zpl_s2;
	logic [47:0] zph_s2;
	logic [39:0] rll_s2;
	logic [39:0] rlh_s2;
	logic [39:0] rhh_s2;
	dv_t         dv_s [D_STEPS+1];
	m1_t         m1_s;
	m2_t         m2_s;
	m3_t         m3_s;
	uv_t         uv_s [U_STEPS+1];
	p1_t         p1_s;
	p2_t         p2_s;
	p3_t         p3_s;
	p4_t         p4_s;
	p5_t         p5_s;
	p6_t         p6_s;
	p7_t         p7_s;
	logic [INTENSITY_W-1:0] out_int_q;
	logic [RADIUS_W-1:0]    out_rad_q;
	logic                   out_sat_q;

	// Constant exponential tables.
	logic [32:0] node_tab [EXP_SEGMENTS+1];
	logic [52:0] epow_tab [32];

	for (genvar j = 0; j <= EXP_SEGMENTS; j++) begin : g_node
		localparam logic [32:0] NV = node_q32(64'(j), 64'(EXP_SEGMENTS));
		assign node_tab[j] = NV;
	end

	for (genvar n = 0; n < 32; n++) begin : g_epow
		localparam logic [52:0] EV = exp_pow(n, 64'(EXP_SEGMENTS));
		assign epow_tab[n] = EV;
	end

	// APB register file; writes complete in the access phase.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wavelength_q <= 24'd1064000;
			waist_q      <= 20'd1000;
			power_q      <= 32'd1000000;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_WAVELENGTH: wavelength_q <= pwdata[WL_W-1:0];
				REG_WAIST:      waist_q      <= pwdata[WAIST_W-1:0];
				REG_POWER:      power_q      <= pwdata[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WAVELENGTH: prdata = APB_DATA_W'(wavelength_q);
			REG_WAIST:      prdata = APB_DATA_W'(waist_q);
			REG_POWER:      prdata = APB_DATA_W'(power_q);
			default:        prdata = '0;
		endcase
	end

	// Derived constants follow the configuration registers every cycle.
	always_ff @(posedge clk) begin
		w0_q      <= (waist_q == '0) ? 20'd1 : waist_q;
		dden_lo_q <= w0_q * PI_Q32_1E6[26:0];
		dden_hi_q <= w0_q * PI_Q32_1E6[53:27];
		dden_q    <= (74'(dden_hi_q) << 27) + 74'(dden_lo_q);
		w0sq_q    <= w0_q * w0_q;
		npk_lo_q  <= power_q * TWO_E12[20:0];
		npk_hi_q  <= power_q * TWO_E12[40:21];
		npk_q     <= (73'(npk_hi_q) << 21) + 73'(npk_lo_q);
	end

	// The whole pipeline moves while the result word is empty or taken.
	assign adv         = !stage_vld_q[N_STG-1] || result.ready;
	assign point.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (adv) begin
			stage_vld_q <= {stage_vld_q[N_STG-2:0], point.valid};
		end
	end

	// Stage 1: magnitudes of the axial distance and the radial offset.
	logic [47:0] z_raw;
	logic [39:0] r_raw;
	assign z_raw = point.axial_distance_um;
	assign r_raw = point.radial_offset_um;

	always_ff @(posedge clk) begin
		if (adv) begin
			za_s1 <= z_raw[47] ? (~z_raw + 48'd1) : z_raw;
			ra_s1 <= r_raw[39] ? (~r_raw + 40'd1) : r_raw;
		end
	end

	// Stage 2: partial products of |z|*lambda and r^2.
	always_ff @(posedge clk) begin
		if (adv) begin
			zpl_s2 <= za_s1[23:0] * wavelength_q;
			zph_s2 <= za_s1[47:24] * wavelength_q;
			rll_s2 <= ra_s1[19:0] * ra_s1[19:0];
			rlh_s2 <= ra_s1[19:0] * ra_s1[39:20];
			rhh_s2 <= ra_s1[39:20] * ra_s1[39:20];
		end
	end

	// Stage 3: sum the partial products and seed the divider for d.
	logic [71:0] numd_c;
	assign numd_c = (72'(zph_s2) << 24) + 72'(zpl_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].numd <= numd_c;
			dv_s[0].r2   <= (80'(rhh_s2) << 40) + (80'(rlh_s2) << 21) + 80'(rll_s2);
			dv_s[0].rem  <= 74'(numd_c[71:16]);
			dv_s[0].q    <= '0;
			dv_s[0].far  <= 1'b0;
		end
	end

	// Division chain for d: one quotient bit per stage. The first step also
	// flags a quotient that would not fit in 56 bits.
	for (genvar k = 1; k <= D_STEPS; k++) begin : g_dstep
		logic        bitv;
		logic        far_c;
		logic [74:0] tt;
		logic        ge;
		dv_t         nxt;

		if (D_STEPS - k >= 40) begin : g_nbit
			assign bitv = dv_s[k-1].numd[D_STEPS-k-40];
		end else begin : g_zbit
			assign bitv = 1'b0;
		end

		if (k == 1) begin : g_far
			assign far_c = 75'(dv_s[k-1].numd[71:16]) >= 75'(dden_q);
		end else begin : g_keep
			assign far_c = dv_s[k-1].far;
		end

		always_comb begin
			nxt     = dv_s[k-1];
			tt      = {dv_s[k-1].rem, bitv};
			ge      = tt >= {1'b0, dden_q};
			nxt.rem = ge ? 74'(tt - {1'b0, dden_q}) : tt[73:0];
			nxt.q   = {dv_s[k-1].q[54:0], ge};
			nxt.far = far_c;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k] <= nxt;
			end
		end
	end

	// Square of d in 28-bit halves.
	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s.r2  <= dv_s[D_STEPS].r2;
			m1_s.far <= dv_s[D_STEPS].far;
			m1_s.dll <= dv_s[D_STEPS].q[27:0] * dv_s[D_STEPS].q[27:0];
			m1_s.dlh <= dv_s[D_STEPS].q[27:0] * dv_s[D_STEPS].q[55:28];
			m1_s.dhh <= dv_s[D_STEPS].q[55:28] * dv_s[D_STEPS].q[55:28];
		end
	end

	// Beam radius squared in Q16.
	always_ff @(posedge clk) begin
		if (adv) begin
			m2_s.s   <= (113'(w0sq_q) << 16) + (113'(m1_s.dhh) << 56) +
				(113'(m1_s.dlh) << 29) + 113'(m1_s.dll);
			m2_s.r2  <= m1_s.r2;
			m2_s.far <= m1_s.far;
		end
	end

	// pi times w^2 in 30-bit slices; very wide beams give zero peak.
	always_ff @(posedge clk) begin
		if (adv) begin
			m3_s.s   <= m2_s.s;
			m3_s.r2  <= m2_s.r2;
			m3_s.far <= m2_s.far;
			m3_s.big <= |m2_s.s[112:90];
			m3_s.ps0 <= m2_s.s[29:0] * PI_Q32;
			m3_s.ps1 <= m2_s.s[59:30] * PI_Q32;
			m3_s.ps2 <= m2_s.s[89:60] * PI_Q32;
		end
	end

	// Seed the peak divider, the square root and the exponent divider.
	logic [112:0] xnum_c;
	assign xnum_c = 113'({m3_s.r2, 12'b0});

	always_ff @(posedge clk) begin
		if (adv) begin
			uv_s[0].s     <= m3_s.s;
			uv_s[0].ps    <= (124'(m3_s.ps2) << 60) + (124'(m3_s.ps1) << 30) +
				124'(m3_s.ps0);
			uv_s[0].far   <= m3_s.far;
			uv_s[0].big   <= m3_s.big;
			uv_s[0].xover <= xnum_c >= m3_s.s;
			uv_s[0].prem  <= 124'(npk_q[72:24]);
			uv_s[0].pq    <= '0;
			uv_s[0].srem  <= '0;
			uv_s[0].root  <= '0;
			uv_s[0].xrem  <= xnum_c;
			uv_s[0].xq    <= '0;
		end
	end

	// Shared chain: peak quotient bit, square-root digit and exponent
	// quotient bit per stage, each unit running its own number of steps.
	for (genvar k = 1; k <= U_STEPS; k++) begin : g_ustep
		logic         pbit;
		logic [124:0] ptt;
		logic         pge;
		uv_t          nxt;

		if (U_STEPS - k >= 48) begin : g_pbit
			assign pbit = npk_q[U_STEPS-k-48];
		end else begin : g_zbit
			assign pbit = 1'b0;
		end

		always_comb begin
			ptt      = {uv_s[k-1].prem, pbit};
			pge      = ptt >= {1'b0, uv_s[k-1].ps};
			nxt      = uv_s[k-1];
			nxt.prem = pge ? 124'(ptt - {1'b0, uv_s[k-1].ps}) : ptt[123:0];
			nxt.pq   = {uv_s[k-1].pq[70:0], pge};
		end

		// Square-root digit for the bit pair of w^2 at this step.
		logic [113:0] s_ext;
		logic [59:0]  stt;
		logic [59:0]  trial;
		logic         sge;
		logic [57:0]  srem_c;
		logic [56:0]  root_c;
		assign s_ext = {1'b0, uv_s[k-1].s};

		if (k <= S_STEPS) begin : g_sq
			always_comb begin
				stt    = {uv_s[k-1].srem, s_ext[2*(S_STEPS-k)+1:2*(S_STEPS-k)]};
				trial  = {1'b0, uv_s[k-1].root, 2'b01};
				sge    = stt >= trial;
				srem_c = sge ? 58'(stt - trial) : stt[57:0];
				root_c = {uv_s[k-1].root[55:0], sge};
			end
		end else begin : g_sqh
			always_comb begin
				stt    = '0;
				trial  = '0;
				sge    = 1'b0;
				srem_c = uv_s[k-1].srem;
				root_c = uv_s[k-1].root;
			end
		end

		// Quotient bit of 2r^2/w^2 in Q16.
		logic [113:0] xtt;
		logic         xge;
		logic [112:0] xrem_c;
		logic [20:0]  xq_c;

		if (k <= X_STEPS) begin : g_xd
			always_comb begin
				xtt    = {uv_s[k-1].xrem, 1'b0};
				xge    = xtt >= {1'b0, uv_s[k-1].s};
				xrem_c = xge ? 113'(xtt - {1'b0, uv_s[k-1].s}) : xtt[112:0];
				xq_c   = {uv_s[k-1].xq[19:0], xge};
			end
		end else begin : g_xh
			always_comb begin
				xtt    = '0;
				xge    = 1'b0;
				xrem_c = uv_s[k-1].xrem;
				xq_c   = uv_s[k-1].xq;
			end
		end

		// Next stage word with the root and exponent-divider fields merged in.
		uv_t nxt_all;

		always_comb begin
			nxt_all      = nxt;
			nxt_all.srem = srem_c;
			nxt_all.root = root_c;
			nxt_all.xrem = xrem_c;
			nxt_all.xq   = xq_c;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				uv_s[k] <= nxt_all;
			end
		end
	end

	// Rounded beam radius, peak, and the table position of the exponent.
	logic [57:0] rsum_c;
	logic [49:0] rad_c;
	assign rsum_c = 58'(uv_s[U_STEPS].root) + 58'd128;
	assign rad_c  = rsum_c[57:8];

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s.far    <= uv_s[U_STEPS].far;
			p1_s.satr   <= |rad_c[49:48];
			p1_s.radius <= (|rad_c[49:48]) ? '1 : rad_c[47:0];
			p1_s.peak   <= uv_s[U_STEPS].big ? '0 : uv_s[U_STEPS].pq;
			p1_s.gzero  <= uv_s[U_STEPS].xover;
			p1_s.t      <= T_W'(uv_s[U_STEPS].xq[15:0]) * T_W'(EXP_SEGMENTS);
			p1_s.xi     <= uv_s[U_STEPS].xq[20:16];
		end
	end

	// Table lookup of the segment ends and of the integer power.
	logic [SEG_W-1:0] seg_c;
	logic [32:0]      na_c;
	logic [32:0]      nb_c;
	assign seg_c = p1_s.t[T_W-1:16];
	assign na_c  = node_tab[seg_c];
	assign nb_c  = node_tab[seg_c + SEG_W'(1)];

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s.far    <= p1_s.far;
			p2_s.satr   <= p1_s.satr;
			p2_s.radius <= p1_s.radius;
			p2_s.peak   <= p1_s.peak;
			p2_s.gzero  <= p1_s.gzero;
			p2_s.a      <= na_c;
			p2_s.b      <= (nb_c > na_c) ? na_c : nb_c;
			p2_s.pos    <= p1_s.t[15:0];
			p2_s.epow   <= epow_tab[p1_s.xi];
		end
	end

	// Interpolation product.
	always_ff @(posedge clk) begin
		if (adv) begin
			p3_s.far    <= p2_s.far;
			p3_s.satr   <= p2_s.satr;
			p3_s.radius <= p2_s.radius;
			p3_s.peak   <= p2_s.peak;
			p3_s.gzero  <= p2_s.gzero;
			p3_s.a      <= p2_s.a;
			p3_s.prod   <= (p2_s.a - p2_s.b) * p2_s.pos;
			p3_s.epow   <= p2_s.epow;
		end
	end

	// Interpolated fractional factor.
	always_ff @(posedge clk) begin
		if (adv) begin
			p4_s.far    <= p3_s.far;
			p4_s.satr   <= p3_s.satr;
			p4_s.radius <= p3_s.radius;
			p4_s.peak   <= p3_s.peak;
			p4_s.gzero  <= p3_s.gzero;
			p4_s.f      <= p3_s.a - 33'(p3_s.prod[48:16]);
			p4_s.epow   <= p3_s.epow;
		end
	end

	// Fractional factor times integer power, in two slices.
	always_ff @(posedge clk) begin
		if (adv) begin
			p5_s.far    <= p4_s.far;
			p5_s.satr   <= p4_s.satr;
			p5_s.radius <= p4_s.radius;
			p5_s.peak   <= p4_s.peak;
			p5_s.gzero  <= p4_s.gzero;
			p5_s.fel    <= p4_s.f * p4_s.epow[25:0];
			p5_s.feh    <= p4_s.f * p4_s.epow[52:26];
		end
	end

	// Gaussian factor in Q32, zero far off the axis.
	logic [85:0] fe_c;
	assign fe_c = (86'(p5_s.feh) << 26) + 86'(p5_s.fel);

	always_ff @(posedge clk) begin
		if (adv) begin
			p6_s.far    <= p5_s.far;
			p6_s.satr   <= p5_s.satr;
			p6_s.radius <= p5_s.radius;
			p6_s.peak   <= p5_s.peak;
			p6_s.g      <= p5_s.gzero ? '0 : fe_c[84:52];
		end
	end

	// Peak times gaussian factor, in 24-bit slices of the peak.
	always_ff @(posedge clk) begin
		if (adv) begin
			p7_s.far    <= p6_s.far;
			p7_s.satr   <= p6_s.satr;
			p7_s.radius <= p6_s.radius;
			p7_s.pp0    <= p6_s.peak[23:0] * p6_s.g;
			p7_s.pp1    <= p6_s.peak[47:24] * p6_s.g;
			p7_s.pp2    <= p6_s.peak[71:48] * p6_s.g;
		end
	end

	// Result word with saturation; a point far from the waist clips the radius.
	logic [104:0] isum_c;
	logic         isat_c;
	assign isum_c = (105'(p7_s.pp2) << 48) + (105'(p7_s.pp1) << 24) + 105'(p7_s.pp0);
	assign isat_c = |isum_c[104:96];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (p7_s.far) begin
				out_int_q <= '0;
				out_rad_q <= '1;
				out_sat_q <= 1'b1;
			end else begin
				out_int_q <= isat_c ? '1 : isum_c[95:32];
				out_rad_q <= p7_s.radius;
				out_sat_q <= p7_s.satr | isat_c;
			end
		end
	end

	assign result.valid               = stage_vld_q[N_STG-1];
	assign result.intensity_uw_per_m2 = out_int_q;
	assign result.beam_radius_um      = out_rad_q;
	assign result.saturated           = out_sat_q;

endmodule

// ===== sim/tb_gaussian_beam_intensity.sv =====
// ----------------------------------------------------------------------------
// Gaussian beam intensity testbench
// Sends evaluation points through the point channel under several register
// settings and idle patterns. Every result word is compared in order with a
// bit-exact fixed-point prediction of radius, intensity and the clip flag.
// ----------------------------------------------------------------------------
module tb_gaussian_beam_intensity;
	import gbi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SEGS        = 64;
	localparam int          WATCH_LIMIT = 5000;
	localparam int          DRAIN_WAIT  = 150;
	localparam logic [1:0]  REG_SPARE   = 2'd3;
	localparam logic [47:0] RADIUS_TOP  = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [63:0] intensity;
		logic [47:0] radius;
		logic        clipped;
	} beam_word_t;

	// Scoreboard: holds the register copies and the queue of predicted words.
	class beam_scoreboard;
		logic [23:0]  wavelength;
		logic [19:0]  waist;
		logic [31:0]  power;
		beam_word_t   pending_words[$];
		int           errors;
		int           checked;
		int           clipped_seen;

		function new();
			wavelength = 24'd1064000;
			waist      = 20'd1000;
			power      = 32'd1000000;
			errors     = 0;
			checked    = 0;
			clipped_seen = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_WAVELENGTH: wavelength = value[23:0];
				REG_WAIST:      waist      = value[19:0];
				REG_POWER:      power      = value;
				default:        ;
			endcase
		endfunction

		// exp(-j/SEGS) in Q52 from a truncated series.
		function logic [63:0] series_node(int unsigned j);
			logic [63:0] sum;
			logic [63:0] term;
			sum  = 0;
			term = 64'd1 << 52;
			for (int k = 0; k < 24; k++) begin
				if ((k % 2) == 0) begin
					sum = sum + term;
				end else begin
					sum = (sum > term) ? sum - term : 64'd0;
				end
				term = term * j / (64'(SEGS) * 64'(k + 1));
			end
			return sum;
		endfunction

		// exp(-x) in Q32 for x in Q16 below 32.
		function logic [63:0] gauss_q32(logic [63:0] x);
			logic [63:0]  whole;
			logic [63:0]  t;
			logic [63:0]  seg;
			logic [63:0]  pos;
			logic [63:0]  a;
			logic [63:0]  b;
			logic [63:0]  f;
			logic [63:0]  e;
			logic [63:0]  e1;
			logic [127:0] pr;
			whole = x >> 16;
			t   = (x & 64'hFFFF) * SEGS;
			seg = t >> 16;
			pos = t & 64'hFFFF;
			a = (series_node(seg) + (64'd1 << 19)) >> 20;
			b = (series_node(seg + 1) + (64'd1 << 19)) >> 20;
			if (b > a) begin
				b = a;
			end
			f  = a - (((a - b) * pos) >> 16);
			e1 = series_node(SEGS);
			e  = 64'd1 << 52;
			for (int i = 0; i < whole; i++) begin
				pr = 128'(e) * 128'(e1);
				e  = pr[115:52];
			end
			pr = 128'(f) * 128'(e);
			return pr[115:52];
		endfunction

		function logic [63:0] floor_sqrt(logic [127:0] s);
			logic [63:0] r;
			logic [63:0] t;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (128'(t) * 128'(t) <= s) begin
					r = t;
				end
			end
			return r;
		endfunction

		// Predict the result word of one accepted point.
		function void note_point(logic [47:0] z, logic [39:0] r);
			logic [47:0]  za;
			logic [39:0]  ra;
			logic [127:0] w0;
			logic [127:0] d;
			logic [127:0] s;
			logic [127:0] p;
			logic [127:0] x;
			logic [127:0] prod;
			logic [64:0]  rad;
			logic [63:0]  g;
			beam_word_t   w;
			za = z[47] ? ~z + 48'd1 : z;
			ra = r[39] ? ~r + 40'd1 : r;
			w0 = (waist == 0) ? 128'd1 : 128'(waist);
			d  = ((128'(za) * 128'(wavelength)) << 40) / (128'(PI_Q32_1E6) * w0);
			if (d >= (128'd1 << 56)) begin
				w.intensity = 0;
				w.radius    = RADIUS_TOP;
				w.clipped   = 1'b1;
				pending_words.push_back(w);
				return;
			end
			w.clipped = 1'b0;
			s   = ((w0 * w0) << 16) + d * d;
			rad = (65'(floor_sqrt(s)) + 65'd128) >> 8;
			if (rad > 65'(RADIUS_TOP)) begin
				rad = 65'(RADIUS_TOP);
				w.clipped = 1'b1;
			end
			w.radius = rad[47:0];
			p = 0;
			if (s < (128'd1 << 90)) begin
				p = ((128'(TWO_E12) * 128'(power)) << 48) / (s * 128'(PI_Q32));
			end
			x = ((128'(ra) * 128'(ra)) << 33) / s;
			g = (x < (128'd32 << 16)) ? gauss_q32(x[63:0]) : 64'd0;
			prod = (p * 128'(g)) >> 32;
			if (prod[127:64] != 0) begin
				w.intensity = '1;
				w.clipped   = 1'b1;
			end else begin
				w.intensity = prod[63:0];
			end
			pending_words.push_back(w);
		endfunction

		// Compare one result word with the oldest prediction.
		function void check_word(logic [63:0] inten, logic [47:0] rad, logic clip);
			beam_word_t w;
			checked++;
			if (clip) begin
				clipped_seen++;
			end
			if (pending_words.size() == 0) begin
				$display("%0t: result word with none expected: I=%0d w=%0d sat=%0b",
					$time, inten, rad, clip);
				errors++;
				return;
			end
			w = pending_words.pop_front();
			if (inten !== w.intensity) begin
				$display("%0t: intensity expected %0d actual %0d", $time, w.intensity, inten);
				errors++;
			end
			if (rad !== w.radius) begin
				$display("%0t: beam radius expected %0d actual %0d", $time, w.radius, rad);
				errors++;
			end
			if (clip !== w.clipped) begin
				$display("%0t: saturated expected %0b actual %0b", $time, w.clipped, clip);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	gbi_point_if  pt();
	gbi_result_if res();

	gaussian_beam_intensity dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.point   (pt.sink),
		.result  (res.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	beam_scoreboard beam_sb = new();
	int             send_idle_pct;
	int             recv_idle_pct;
	int             hold_cycles;
	int             quiet_cycles;
	int             points_sent;

	// Clock.
	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	// Receiver: random stalls, a long hold-off on request, and checking.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				beam_sb.check_word(res.intensity_uw_per_m2, res.beam_radius_um,
					res.saturated);
			end
		end
	end

	// Watchdog on cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if ((pt.valid && pt.ready) || (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $time, WATCH_LIMIT);
			$display("tb_gaussian_beam_intensity: FAIL");
			$finish;
		end
	end

	// Register write with a setup and an access cycle.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		beam_sb.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one point word and wait until it is accepted.
	task automatic send_point(logic [47:0] z, logic [39:0] r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pt.valid <= 1'b0;
			@(negedge clk);
		end
		pt.valid             <= 1'b1;
		pt.axial_distance_um <= z;
		pt.radial_offset_um  <= r;
		do begin
			@(posedge clk);
		end while (pt.ready !== 1'b1);
		beam_sb.note_point(z, r);
		points_sent++;
	endtask

	// Wait until every predicted word has come back and the pipeline is quiet.
	task automatic drain();
		@(negedge clk);
		pt.valid <= 1'b0;
		while (beam_sb.pending_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Random magnitude spread over many octaves, with a random sign.
	function automatic logic [63:0] spread_value();
		logic [63:0] v;
		v = {$urandom, $urandom} >> $urandom_range(63);
		return ($urandom_range(1) != 0) ? -v : v;
	endfunction

	task automatic send_random(int count);
		logic [47:0] z;
		logic [39:0] r;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(7) == 0) begin
				z = {$urandom, $urandom};
				r = {$urandom, $urandom};
			end else begin
				z = spread_value();
				r = spread_value();
			end
			send_point(z, r);
		end
	endtask

	// Main sequence.
	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		pt.valid = 1'b0;
		pt.axial_distance_um = '0;
		pt.radial_offset_um  = '0;
		send_idle_pct = 23;
		recv_idle_pct = 80;
		hold_cycles   = 0;
		quiet_cycles  = 0;
		points_sent   = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed points under the reset settings.
		send_point(48'd0, 40'd0);
		send_point(48'h7FFF_FFFF_FFFF, 40'h7F_FFFF_FFFF);
		send_point(48'h8000_0000_0000, 40'h80_0000_0000);
		send_point(48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_point(48'd0, 40'd1000);
		send_point(48'd0, -40'sd1000);
		send_point(48'd2950000, 40'd1414);
		send_point(-48'sd2950000, 40'd707);
		send_point(48'd0, 40'd4000);
		send_point(48'd0, 40'd5000);
		send_point(48'd1000000000, 40'd0);
		send_point(48'h5555_5555_5555, 40'hAA_AAAA_AAAA);
		send_point(48'hAAAA_AAAA_AAAA, 40'h55_5555_5555);
		send_random(90);
		drain();

		// Longest wavelength, smallest waist, full power: far-field clipping.
		write_reg(REG_WAVELENGTH, 32'hFF_FFFF);
		write_reg(REG_WAIST, 32'd1);
		write_reg(REG_POWER, 32'hFFFF_FFFF);
		send_point(48'd0, 40'd0);
		send_point(48'h7FFF_FFFF_FFFF, 40'd0);
		send_point(48'd1, 40'd1);
		send_random(100);
		drain();

		// Zero registers, a write to the spare address and wide data bits.
		send_idle_pct = 80;
		recv_idle_pct = 23;
		write_reg(REG_WAVELENGTH, 32'd0);
		write_reg(REG_WAIST, 32'd0);
		write_reg(REG_POWER, 32'd0);
		write_reg(REG_SPARE, 32'hDEAD_BEEF);
		send_point(48'h7FFF_FFFF_FFFF, 40'd0);
		send_random(60);
		drain();
		write_reg(REG_POWER, 32'hFFFF_FFFF);
		write_reg(REG_WAIST, 32'hFFF0_0000);
		send_point(48'd0, 40'd0);
		send_random(40);
		drain();

		// Shortest wavelength and widest waist.
		write_reg(REG_WAVELENGTH, 32'd1);
		write_reg(REG_WAIST, 32'hF_FFFF);
		send_point(48'h8000_0000_0000, 40'h7F_FFFF_FFFF);
		send_random(100);
		drain();

		// No idling, with a long receiver hold-off that backs up the input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_WAVELENGTH, $urandom_range(24'hFF_FFFF, 1));
		write_reg(REG_WAIST, $urandom_range(20'hF_FFFF, 1));
		write_reg(REG_POWER, $urandom);
		hold_cycles = 400;
		send_random(200);
		drain();

		// Back near the reset settings with a random power.
		write_reg(REG_WAVELENGTH, 32'd1064000);
		write_reg(REG_WAIST, $urandom_range(5000, 1));
		write_reg(REG_POWER, $urandom);
		send_random(10);
		drain();

		$display("Sent %0d points over seven register settings; checked %0d words, %0d clipped.",
			points_sent, beam_sb.checked, beam_sb.clipped_seen);
		if (beam_sb.errors == 0 && beam_sb.pending_words.size() == 0) begin
			$display("tb_gaussian_beam_intensity: PASS");
		end else begin
			$display("tb_gaussian_beam_intensity: FAIL");
		end
		$finish;
	end

endmodule
